// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Helpers for the concurrent checks of the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ppt_pkg.sv -----
// ----------------------------------------------------------------------------
// ppt_pkg
// Types and constants of the image byte tweaker stream unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] mode_type;

   // Header characters.
   localparam byte_type SEP_SPACE    = 8'h20;
   localparam byte_type SEP_NEWLINE  = 8'h0A;
   localparam byte_type COMMENT_MARK = 8'h23;

   // Number of separators that close the header.
   localparam logic [2:0] HEADER_SEPARATORS = 3'd4;

   // Pixel tweak modes; the two unused codes behave as pass.
   localparam mode_type MODE_PASS     = 3'd0;
   localparam mode_type MODE_BRIGHTEN = 3'd1;
   localparam mode_type MODE_DARKEN   = 3'd2;
   localparam mode_type MODE_REDDEN   = 3'd3;
   localparam mode_type MODE_GRAY     = 3'd4;
   localparam mode_type MODE_SWAP     = 3'd5;

   // Color phases of a pixel.
   localparam logic [1:0] PHASE_RED   = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_BLUE  = 2'd2;

   // floor(x / 3) == (x * 683) >> 11 for every x up to 765.
   localparam logic [19:0] GRAY_RECIP = 20'd683;
   localparam int          GRAY_SHIFT = 11;

endpackage

`default_nettype wire

// ----- rtl/core/ppt_stream_if.sv -----
// ----------------------------------------------------------------------------
// ppt stream interfaces
// Valid/ready channels for raw file bytes in and tweaked bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ppt_req_if
   import ppt_pkg::*;
   ;
   logic     valid;
   logic     ready;
   byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppt_rsp_if
   import ppt_pkg::*;
   ;
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ppm_pixel_tweak_stream_unit.sv -----
// ----------------------------------------------------------------------------
// ppm_pixel_tweak_stream_unit
// Byte-serial tweaker for binary RGB image files.
// ----------------------------------------------------------------------------
// The unit takes one file byte per beat and accepts a new byte in every cycle
// unless its result register is busy. A byte goes through an input register, is
// decoded against the header and pixel state, and its results land in a
// three-entry result register that drives one beat per cycle while the
// receiver is ready. Header and pixel bytes in pass, brighten, darken and
// redden modes give one beat each and stream at one byte per cycle unless held
// off. In grayscale and swap modes the red and green bytes give no beat and the
// blue byte gives three. Header comments are dropped. The mode register must be
// written only while the unit is idle, unchecked by the unit; reset starts a new image.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ppm_pixel_tweak_stream_unit
   import ppt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   ppt_req_if.sink       req_chan,
   ppt_rsp_if.source     rsp_chan,
   input  wire logic     csr_wr_en,
   input  wire mode_type csr_wr_data
);

   // Registers.
   mode_type   mode_ff, mode_in;
   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff, in_byte_in;
   logic [2:0] header_left_ff, header_left_in;
   logic       in_comment_ff, in_comment_in;
   logic [1:0] phase_ff, phase_in;
   byte_type   held_red_ff, held_red_in;
   byte_type   held_green_ff, held_green_in;
   logic [1:0] run_cnt_ff, run_cnt_in;
   byte_type   run_byte_ff [3];
   byte_type   run_byte_in [3];

   // Handshake terms.
   logic pop;
   logic run_free;
   logic advance;

   // Decode of the byte in the input register.
   logic       is_sep;
   logic       is_pixel;
   byte_type   b;
   byte_type   twice_b;
   byte_type   half_b;
   logic [9:0] gray_sum;
   logic [19:0] gray_prod;
   byte_type   gray_avg;
   logic [1:0] new_cnt;
   byte_type   new_byte [3];

   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign run_free = (run_cnt_ff == 2'd0) || (pop && run_cnt_ff == 2'd1);
   assign advance  = in_valid_ff && run_free;

   assign req_chan.ready       = !in_valid_ff || advance;
   assign rsp_chan.valid       = run_cnt_ff != 2'd0;
   assign rsp_chan.out_byte    = run_byte_ff[0];
   assign rsp_chan.last_of_run = run_cnt_ff == 2'd1;

   // Pixel arithmetic on the registered byte.
   assign b         = in_byte_ff;
   assign is_sep    = (b == SEP_SPACE) || (b == SEP_NEWLINE);
   assign is_pixel  = !in_comment_ff && header_left_ff == 3'd0;
   assign twice_b   = b[7] ? 8'hFF : {b[6:0], 1'b0};
   assign half_b    = {1'b0, b[7:1]};
   assign gray_sum  = {2'b00, held_red_ff} + {2'b00, held_green_ff} + {2'b00, b};
   assign gray_prod = {10'd0, gray_sum} * GRAY_RECIP;
   assign gray_avg  = gray_prod[GRAY_SHIFT +: 8];

   // Result beats caused by the byte in the input register.
   always_comb begin
      new_cnt     = 2'd1;
      new_byte[0] = b;
      new_byte[1] = b;
      new_byte[2] = b;
      if (in_comment_ff) begin
         new_cnt = 2'd0;
      end else if (header_left_ff != 3'd0) begin
         if (!is_sep && b == COMMENT_MARK) begin
            new_cnt = 2'd0;
         end
      end else begin
         case (mode_ff)
            MODE_BRIGHTEN: begin
               new_byte[0] = twice_b;
            end
            MODE_DARKEN: begin
               new_byte[0] = half_b;
            end
            MODE_REDDEN: begin
               new_byte[0] = (phase_ff == PHASE_RED) ? twice_b : half_b;
            end
            MODE_GRAY: begin
               new_cnt     = (phase_ff == PHASE_BLUE) ? 2'd3 : 2'd0;
               new_byte[0] = gray_avg;
               new_byte[1] = gray_avg;
               new_byte[2] = gray_avg;
            end
            MODE_SWAP: begin
               new_cnt     = (phase_ff == PHASE_BLUE) ? 2'd3 : 2'd0;
               new_byte[0] = b;
               new_byte[1] = held_red_ff;
               new_byte[2] = held_green_ff;
            end
            default: begin
               new_byte[0] = b;
            end
         endcase
      end
   end

   // Next state of the registers.
   always_comb begin
      mode_in        = csr_wr_en ? csr_wr_data : mode_ff;
      in_valid_in    = in_valid_ff;
      in_byte_in     = in_byte_ff;
      header_left_in = header_left_ff;
      in_comment_in  = in_comment_ff;
      phase_in       = phase_ff;
      held_red_in    = held_red_ff;
      held_green_in  = held_green_ff;
      run_cnt_in     = run_cnt_ff;
      run_byte_in    = run_byte_ff;

      // Input register.
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.data_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // Result register: shift out a taken beat.
      if (pop) begin
         run_cnt_in     = run_cnt_ff - 2'd1;
         run_byte_in[0] = run_byte_ff[1];
         run_byte_in[1] = run_byte_ff[2];
      end

      // Consume the input register byte and update the image state.
      if (advance) begin
         run_cnt_in  = new_cnt;
         run_byte_in = new_byte;
         if (in_comment_ff) begin
            if (b == SEP_NEWLINE) begin
               in_comment_in = 1'b0;
            end
         end else if (header_left_ff != 3'd0) begin
            if (is_sep) begin
               header_left_in = header_left_ff - 3'd1;
            end else if (b == COMMENT_MARK) begin
               in_comment_in = 1'b1;
            end
         end else begin
            phase_in = (phase_ff == PHASE_BLUE) ? PHASE_RED : phase_ff + 2'd1;
            if (phase_ff == PHASE_RED) begin
               held_red_in = b;
            end else if (phase_ff == PHASE_GREEN) begin
               held_green_in = b;
            end
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      run_byte_ff <= run_byte_in;
      if (reset) begin
         mode_ff        <= MODE_PASS;
         in_valid_ff    <= 1'b0;
         header_left_ff <= HEADER_SEPARATORS;
         in_comment_ff  <= 1'b0;
         phase_ff       <= PHASE_RED;
         held_red_ff    <= 8'd0;
         held_green_ff  <= 8'd0;
         run_cnt_ff     <= 2'd0;
      end else begin
         mode_ff        <= mode_in;
         in_valid_ff    <= in_valid_in;
         header_left_ff <= header_left_in;
         in_comment_ff  <= in_comment_in;
         phase_ff       <= phase_in;
         held_red_ff    <= held_red_in;
         held_green_ff  <= held_green_in;
         run_cnt_ff     <= run_cnt_in;
      end
   end

   // Checks.
   `ASSERT_CLK(a_header_bound, clock, reset, header_left_ff <= HEADER_SEPARATORS, "header count above four")
   `ASSERT_CLK(a_comment_in_header, clock, reset, in_comment_ff |-> header_left_ff != 3'd0, "comment outside header")
   `ASSERT_CLK(a_phase_range, clock, reset, phase_ff != 2'd3, "bad color phase")
   `ASSERT_CLK(a_blue_run, clock, reset, advance && is_pixel && phase_ff == PHASE_BLUE && (mode_ff == MODE_GRAY || mode_ff == MODE_SWAP) |=> run_cnt_ff == 2'd3, "blue byte lost its three beats")

endmodule

`default_nettype wire

// ----- bench/tb_ppm_pixel_tweak_stream_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppm_pixel_tweak_stream_unit
// Streams one image file through the byte tweaker and checks each output beat
// against a shadow of the header parser and the pixel modes. A short directed
// header with a comment comes first, then pixel data under every mode code.
// ----------------------------------------------------------------------------

module tb_ppm_pixel_tweak_stream_unit;
   import ppt_pkg::*;

   // The two spare mode codes behave as pass.
   localparam mode_type MODE_SPARE_LO  = 3'd6;
   localparam mode_type MODE_SPARE_HI  = 3'd7;
   localparam int       STALL_LIMIT    = 2000;
   localparam int       SQUEEZE_CYCLES = 60;
   localparam int       DRAIN_CYCLES   = 8;
   localparam int       RESET_CYCLES   = 12;

   typedef struct packed {
      byte_type out_byte;
      logic     last_of_run;
   } out_beat_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_wr_en;
   mode_type csr_wr_data;

   ppt_req_if req_chan ();
   ppt_rsp_if rsp_chan ();

   ppm_pixel_tweak_stream_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // File bytes waiting to be sent and output beats still owed by the unit.
   byte_type     file_bytes[$];
   out_beat_type expected_beats[$];

   // Shadow of the unit's parser and pixel state.
   mode_type   shadow_mode;
   logic [2:0] seps_left;
   logic       comment_open;
   logic [1:0] pix_slot;
   byte_type   held_r;
   byte_type   held_g;

   int errors;
   int bytes_sent;
   int beats_seen;
   int mode_writes;
   int idle_cycles;
   int send_gap;
   int recv_hold;
   bit eager;
   bit squeeze_armed;
   bit squeeze_done;

   always #5 clock = ~clock;

   // Advance the shadow by one accepted file byte and queue the beats it owes.
   function automatic void tweak_byte(input byte_type b);
      logic [1:0] slot;
      logic [9:0] sum;
      byte_type   doubled;
      byte_type   halved;
      byte_type   gray;
      doubled = b[7] ? 8'hFF : {b[6:0], 1'b0};
      halved  = b >> 1;
      if (comment_open) begin
         // Comment text is dropped, its closing newline included.
         if (b == SEP_NEWLINE) comment_open = 1'b0;
      end else if (seps_left != 3'd0) begin
         if (b == SEP_NEWLINE || b == SEP_SPACE) begin
            seps_left = seps_left - 3'd1;
            expected_beats.push_back('{out_byte: b, last_of_run: 1'b1});
         end else if (b == COMMENT_MARK) begin
            comment_open = 1'b1;
         end else begin
            expected_beats.push_back('{out_byte: b, last_of_run: 1'b1});
         end
      end else begin
         // Pixel data: the color slot and held values move in every mode.
         slot     = pix_slot;
         pix_slot = (slot == PHASE_BLUE) ? PHASE_RED : slot + 2'd1;
         if (slot == PHASE_RED) held_r = b;
         else if (slot == PHASE_GREEN) held_g = b;
         sum  = 10'(held_r) + 10'(held_g) + 10'(b);
         gray = 8'(sum / 10'd3);
         case (shadow_mode)
            MODE_BRIGHTEN: begin
               expected_beats.push_back('{out_byte: doubled, last_of_run: 1'b1});
            end
            MODE_DARKEN: begin
               expected_beats.push_back('{out_byte: halved, last_of_run: 1'b1});
            end
            MODE_REDDEN: begin
               expected_beats.push_back('{out_byte: (slot == PHASE_RED) ? doubled : halved,
                                          last_of_run: 1'b1});
            end
            MODE_GRAY: begin
               if (slot == PHASE_BLUE) begin
                  expected_beats.push_back('{out_byte: gray, last_of_run: 1'b0});
                  expected_beats.push_back('{out_byte: gray, last_of_run: 1'b0});
                  expected_beats.push_back('{out_byte: gray, last_of_run: 1'b1});
               end
            end
            MODE_SWAP: begin
               if (slot == PHASE_BLUE) begin
                  expected_beats.push_back('{out_byte: b, last_of_run: 1'b0});
                  expected_beats.push_back('{out_byte: held_r, last_of_run: 1'b0});
                  expected_beats.push_back('{out_byte: held_g, last_of_run: 1'b1});
               end
            end
            default: begin
               expected_beats.push_back('{out_byte: b, last_of_run: 1'b1});
            end
         endcase
      end
   endfunction

   // Sender: presents queued file bytes with a random gap after each one unless eager.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.data_byte <= '0;
         send_gap           <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            tweak_byte(req_chan.data_byte);
            bytes_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               req_chan.valid <= 1'b0;
               send_gap       <= send_gap - 1;
            end else if (file_bytes.size() > 0) begin
               req_chan.valid     <= 1'b1;
               req_chan.data_byte <= file_bytes.pop_front();
               send_gap           <= eager ? 0 : $urandom_range(0, 5);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each output beat and then holds off for a random time, once for a long squeeze.
   always @(posedge clock) begin : rsp_side
      out_beat_type want;
      int           wait_n;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_hold      <= 0;
      end else begin
         wait_n = recv_hold;
         if (rsp_chan.valid && rsp_chan.ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
               $error("beat with none owed: out_byte %02h last_of_run %0b",
                      rsp_chan.out_byte, rsp_chan.last_of_run);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_chan.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h",
                         want.out_byte, rsp_chan.out_byte);
                  errors++;
               end
               if (rsp_chan.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, actual %0b",
                         want.last_of_run, rsp_chan.last_of_run);
                  errors++;
               end
            end
            // One long hold-off lets the unit fill up and stall its input.
            if (squeeze_armed && !squeeze_done) begin
               wait_n       = SQUEEZE_CYCLES;
               squeeze_done = 1'b1;
            end else begin
               wait_n = eager ? 0 : $urandom_range(0, 5);
            end
         end
         if (wait_n > 0) begin
            rsp_chan.ready <= 1'b0;
            recv_hold      <= wait_n - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
            recv_hold      <= 0;
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles, %0d beats still owed",
                  idle_cycles, expected_beats.size());
         $display("tb_ppm_pixel_tweak_stream_unit: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Wait until every byte is sent and every owed beat has arrived, then let
   // the pipeline settle, since dropped comment bytes leave nothing to wait on.
   task automatic wait_drained();
      while (file_bytes.size() != 0 || req_chan.valid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mode writes happen only with the unit drained.
   task automatic set_mode(input mode_type m);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_mode = m;
      mode_writes++;
   endtask

   initial begin
      byte_type header_bytes[$];
      byte_type pix;
      mode_type plan[12];
      int       len;

      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      rsp_chan.ready     = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = MODE_PASS;
      eager              = 1'b0;
      squeeze_armed      = 1'b0;
      shadow_mode        = MODE_PASS;
      seps_left          = HEADER_SEPARATORS;
      comment_open       = 1'b0;
      pix_slot           = PHASE_RED;
      held_r             = '0;
      held_g             = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_mode(MODE_PASS);

      // Header with extreme bytes, a comment holding a space and a second
      // comment mark, then width, height and maximum value.
      header_bytes = '{"P", "6", 8'hFF, 8'h00, SEP_NEWLINE,
                       COMMENT_MARK, SEP_SPACE, COMMENT_MARK, "x", SEP_NEWLINE,
                       "1", SEP_SPACE, "1", SEP_NEWLINE, "2", "5", "5", SEP_NEWLINE};
      // First pixel bytes: extremes and header characters taken as data.
      header_bytes = {header_bytes, 8'h00, 8'hFF, SEP_SPACE, SEP_NEWLINE,
                      COMMENT_MARK, 8'h80, 8'h7F};
      foreach (header_bytes[k]) file_bytes.push_back(header_bytes[k]);

      // Random pixel data under each mode code; partial pixels carry over.
      plan = '{MODE_BRIGHTEN, MODE_DARKEN, MODE_REDDEN, MODE_GRAY, MODE_SWAP,
               MODE_SPARE_LO, MODE_SPARE_HI, MODE_PASS, MODE_SWAP, MODE_GRAY,
               MODE_REDDEN, MODE_BRIGHTEN};
      foreach (plan[p]) begin
         set_mode(plan[p]);
         eager = (p == 1 || p == 7);
         if (p == 1) begin
            squeeze_armed = 1'b1;
            len = 30;
         end else begin
            len = 3 * $urandom_range(3, 4) + $urandom_range(0, 2);
         end
         repeat (len) begin
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 4))
                  0:       pix = 8'h00;
                  1:       pix = 8'hFF;
                  2:       pix = SEP_SPACE;
                  3:       pix = SEP_NEWLINE;
                  default: pix = COMMENT_MARK;
               endcase
            end else begin
               pix = 8'($urandom_range(0, 255));
            end
            file_bytes.push_back(pix);
         end
      end

      wait_drained();
      $display("Sent %0d file bytes (header with comment, then pixels) and checked %0d beats.",
               bytes_sent, beats_seen);
      $display("Wrote the mode %0d times across all eight codes, with one long output stall.",
               mode_writes);
      if (errors == 0) begin
         $display("tb_ppm_pixel_tweak_stream_unit: clean");
      end else begin
         $display("tb_ppm_pixel_tweak_stream_unit: errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ppt_pkg.sv
rtl/core/ppt_stream_if.sv
rtl/core/ppm_pixel_tweak_stream_unit.sv
bench/tb_ppm_pixel_tweak_stream_unit.sv
